>>> sv/assert_macros.svh
// assertion macros used by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/u8dgw_pkg.sv
// types, constants and codepoint classification for the utf-8 decoder
package u8dgw_pkg;

  localparam logic [20:0] ReplCp = 21'h00FFFD;
  localparam logic [20:0] ZwjCp  = 21'h00200D;

  localparam logic [1:0] WidthZero   = 2'd0;
  localparam logic [1:0] WidthNarrow = 2'd1;
  localparam logic [1:0] WidthWide   = 2'd2;

  localparam logic [2:0] NeedBad = 3'd0;

  typedef struct packed {
    logic [20:0] code_point;
    logic        is_replacement;
    logic [2:0]  source_len;
    logic        starts_cluster;
    logic [1:0]  cell_width;
    logic        run_last;
    logic        ends_text;
  } result_t;

  function automatic logic in_rng(logic [20:0] c, logic [20:0] lo, logic [20:0] hi);
    return (c >= lo) && (c <= hi);
  endfunction

  function automatic logic is_combining(logic [20:0] c);
    return in_rng(c, 21'h0300, 21'h036F) || in_rng(c, 21'h1AB0, 21'h1AFF) ||
           in_rng(c, 21'h1DC0, 21'h1DFF) || in_rng(c, 21'h20D0, 21'h20FF) ||
           in_rng(c, 21'hFE20, 21'hFE2F);
  endfunction

  function automatic logic is_selector(logic [20:0] c);
    return in_rng(c, 21'hFE00, 21'hFE0F);
  endfunction

  function automatic logic is_wide(logic [20:0] c);
    return in_rng(c, 21'h1100, 21'h115F) || in_rng(c, 21'h2E80, 21'hA4CF) ||
           in_rng(c, 21'hAC00, 21'hD7A3) || in_rng(c, 21'hF900, 21'hFAFF) ||
           in_rng(c, 21'hFE10, 21'hFE19) || in_rng(c, 21'hFE30, 21'hFE6F) ||
           in_rng(c, 21'hFF00, 21'hFF60) || in_rng(c, 21'hFFE0, 21'hFFE6);
  endfunction

  // marks that always attach to the open cluster
  function automatic logic is_attaching(logic [20:0] c);
    return is_combining(c) || is_selector(c) || (c == ZwjCp);
  endfunction

  function automatic logic [1:0] width_of(logic [20:0] c);
    if (is_attaching(c) || (c < 21'h20) || (c == 21'h7F)) begin
      return WidthZero;
    end
    return is_wide(c) ? WidthWide : WidthNarrow;
  endfunction

  // sequence length announced by a lead byte, NeedBad for an illegal lead
  function automatic logic [2:0] need_of(logic [7:0] lead);
    if (lead[7] == 1'b0) begin
      return 3'd1;
    end else if (lead[7:5] == 3'b110) begin
      return 3'd2;
    end else if (lead[7:4] == 4'b1110) begin
      return 3'd3;
    end else if (lead[7:3] == 5'b11110) begin
      return 3'd4;
    end
    return NeedBad;
  endfunction

endpackage

>>> sv/utf8_decode_grapheme_width_top.sv
// utf-8 stream decoder with replacement, cluster marking and cell width
// One text byte is taken per handshake; a taken byte is followed by one decode
// step for each codepoint it completes, or a single step when it completes
// none and only waits for more continuation bytes. A byte that flushes more
// than one codepoint (after a broken sequence or at the end of text) holds the
// input until the last of them is out. The single decode step looks at the
// four-byte pending buffer, produces one codepoint and shifts the buffer, one
// codepoint per cycle while the output register is not stalled; a stall holds
// the step. While decoding, in_stall_o is high.
// Bad leads and broken continuations give U+FFFD for one byte, a sequence
// cut short by text_end gives one U+FFFD covering the rest; overlong forms
// and surrogates pass through unchecked.
`include "assert_macros.svh"

module utf8_decode_grapheme_width_top
  import u8dgw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        text_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [20:0] code_point_o,
  output logic        is_replacement_o,
  output logic [2:0]  source_len_o,
  output logic        starts_cluster_o,
  output logic [1:0]  cell_width_o,
  output logic        run_last_o,
  output logic        ends_text_o
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_DECODE = 1'b1;

  logic        state_q, state_d;
  logic [7:0]  pend_q [4];
  logic [7:0]  pend_d [4];
  logic [2:0]  cnt_q, cnt_d;
  logic        joiner_q, joiner_d;
  logic        open_q, open_d;
  logic        end_q, end_d;
  logic        out_valid_q;
  result_t     out_q;

  // decode step signals
  logic [7:0]  lead;
  logic [2:0]  need;
  logic        cont_ok;
  logic        short_seq;
  logic        wait_w;
  logic [20:0] cp_val;
  logic        repl;
  logic [2:0]  drop;
  logic [2:0]  rest;
  logic [7:0]  nxt_lead;
  logic [2:0]  nxt_need;
  logic        is_last;
  logic        out_free;
  logic        emit_w;
  logic        accept_w;
  result_t     res;

  assign accept_w = (state_q == ST_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;

  assign lead      = pend_q[0];
  assign need      = need_of(lead);
  // a multi-byte lead with too few bytes buffered
  assign short_seq = (need > 3'd1) && (cnt_q < need);
  assign wait_w    = short_seq && !end_q;

  always_comb begin
    case (need)
      3'd2:    cont_ok = (pend_q[1][7:6] == 2'b10);
      3'd3:    cont_ok = (pend_q[1][7:6] == 2'b10) && (pend_q[2][7:6] == 2'b10);
      3'd4:    cont_ok = (pend_q[1][7:6] == 2'b10) && (pend_q[2][7:6] == 2'b10) &&
                         (pend_q[3][7:6] == 2'b10);
      default: cont_ok = 1'b1;
    endcase
  end

  always_comb begin
    case (need)
      3'd2:    cp_val = {10'd0, lead[4:0], pend_q[1][5:0]};
      3'd3:    cp_val = {5'd0, lead[3:0], pend_q[1][5:0], pend_q[2][5:0]};
      3'd4:    cp_val = {lead[2:0], pend_q[1][5:0], pend_q[2][5:0], pend_q[3][5:0]};
      default: cp_val = {13'd0, lead};
    endcase
  end

  always_comb begin
    if (need == NeedBad) begin
      repl = 1'b1;
      drop = 3'd1;
    end else if (short_seq) begin
      // truncated at end of text: swallow everything left
      repl = 1'b1;
      drop = cnt_q;
    end else if (!cont_ok) begin
      repl = 1'b1;
      drop = 3'd1;
    end else begin
      repl = 1'b0;
      drop = need;
    end
  end

  // look ahead at the buffer after the shift to tell whether this is the
  // last codepoint of the byte
  assign rest     = cnt_q - drop;
  assign nxt_lead = pend_q[drop[1:0]];
  assign nxt_need = need_of(nxt_lead);
  assign is_last  = (rest == 3'd0) ||
                    ((nxt_need > 3'd1) && (rest < nxt_need) && !end_q);

  assign emit_w = (state_q == ST_DECODE) && !wait_w && out_free;

  always_comb begin
    res.code_point     = repl ? ReplCp : cp_val;
    res.is_replacement = repl;
    res.source_len     = drop;
    // joins the open cluster after a joiner or for an attaching mark
    res.starts_cluster = !(open_q && (is_attaching(res.code_point) || joiner_q));
    res.cell_width     = width_of(res.code_point);
    res.run_last       = is_last;
    res.ends_text      = is_last && end_q;
  end

  // sequencer and buffer update
  always_comb begin
    logic [2:0] src;
    state_d  = state_q;
    cnt_d    = cnt_q;
    joiner_d = joiner_q;
    open_d   = open_q;
    end_d    = end_q;
    for (int i = 0; i < 4; i++) begin
      pend_d[i] = pend_q[i];
    end
    src = 3'd0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept_w) begin
          pend_d[cnt_q[1:0]] = in_byte_i;
          cnt_d   = cnt_q + 3'd1;
          end_d   = text_end_i;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (wait_w) begin
          state_d = ST_IDLE;
        end else if (emit_w) begin
          for (int i = 0; i < 4; i++) begin
            src = 3'(i) + drop;
            if (src < 3'd4) begin
              pend_d[i] = pend_q[src[1:0]];
            end
          end
          cnt_d    = rest;
          joiner_d = (res.code_point == ZwjCp);
          open_d   = 1'b1;
          if (is_last) begin
            state_d = ST_IDLE;
            if (end_q) begin
              // next byte starts a fresh text
              cnt_d    = 3'd0;
              joiner_d = 1'b0;
              open_d   = 1'b0;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= 3'd0;
      joiner_q    <= 1'b0;
      open_q      <= 1'b0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      joiner_q <= joiner_d;
      open_q   <= open_d;
      end_q    <= end_d;
      if (emit_w) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      pend_q[i] <= pend_d[i];
    end
    if (emit_w) begin
      out_q <= res;
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign code_point_o     = out_q.code_point;
  assign is_replacement_o = out_q.is_replacement;
  assign source_len_o     = out_q.source_len;
  assign starts_cluster_o = out_q.starts_cluster;
  assign cell_width_o     = out_q.cell_width;
  assign run_last_o       = out_q.run_last;
  assign ends_text_o      = out_q.ends_text;

  // a byte can only be taken while the buffer has room for it
  `ASSERT_IMPLY(a_room_on_accept, state_q == ST_IDLE, cnt_q <= 3'd3, "pending buffer full in idle")
  // the end of a text always closes the byte's run
  `ASSERT_IMPLY(a_end_is_last, out_valid_q && out_q.ends_text, out_q.run_last,
                "ends_text without run_last")
  // after the final codepoint of a text, nothing stays pending
  `ASSERT_NEXT(a_end_drains, emit_w && res.ends_text,
               cnt_q == 3'd0 && !open_q && !joiner_q, "state not cleared at end of text")
  // a consumed length never exceeds what is buffered
  `ASSERT_IMPLY(a_drop_bounded, emit_w, drop <= cnt_q && drop != 3'd0,
                "decode consumed more than buffered")

endmodule

>>> tb/sv/u8dgw_tb_pkg.sv
// codepoint predictor and result scoreboard for the utf-8 decoder testbench
`timescale 1ns / 1ps

package u8dgw_tb_pkg;
  import u8dgw_pkg::*;

  class codepoint_board;
    result_t     expected_cps[$];
    int unsigned failures = 0;

    // decoder state as the predictor sees it
    logic [7:0]  held[4] = '{8'h00, 8'h00, 8'h00, 8'h00};
    int unsigned held_cnt = 0;
    bit          after_joiner = 0;
    bit          in_cluster = 0;

    function bit within_span(logic [20:0] c, logic [20:0] lo, logic [20:0] hi);
      return (c >= lo) && (c <= hi);
    endfunction

    // combining marks, variation selectors and the joiner
    function bit attaches(logic [20:0] c);
      return within_span(c, 21'h0300, 21'h036F) || within_span(c, 21'h1AB0, 21'h1AFF) ||
             within_span(c, 21'h1DC0, 21'h1DFF) || within_span(c, 21'h20D0, 21'h20FF) ||
             within_span(c, 21'hFE20, 21'hFE2F) || within_span(c, 21'hFE00, 21'hFE0F) ||
             (c == ZwjCp);
    endfunction

    function logic [1:0] columns_of(logic [20:0] c);
      if (attaches(c) || (c < 21'h20) || (c == 21'h7F)) begin
        return WidthZero;
      end
      if (within_span(c, 21'h1100, 21'h115F) || within_span(c, 21'h2E80, 21'hA4CF) ||
          within_span(c, 21'hAC00, 21'hD7A3) || within_span(c, 21'hF900, 21'hFAFF) ||
          within_span(c, 21'hFE10, 21'hFE19) || within_span(c, 21'hFE30, 21'hFE6F) ||
          within_span(c, 21'hFF00, 21'hFF60) || within_span(c, 21'hFFE0, 21'hFFE6)) begin
        return WidthWide;
      end
      return WidthNarrow;
    endfunction

    function void push_cp(logic [20:0] cp, bit repl, int unsigned len);
      result_t r;
      r.code_point     = cp;
      r.is_replacement = repl;
      r.source_len     = len[2:0];
      r.starts_cluster = !(in_cluster && (attaches(cp) || after_joiner));
      r.cell_width     = columns_of(cp);
      r.run_last       = 1'b0;
      r.ends_text      = 1'b0;
      expected_cps = {expected_cps, r};
      in_cluster   = 1;
      after_joiner = (cp == ZwjCp);
    endfunction

    function void drop_held(int unsigned n);
      int unsigned i;
      for (i = 0; i < 4; i++) begin
        if (i + n < 4) held[i] = held[i + n];
      end
      held_cnt = held_cnt - n;
    endfunction

    // an accepted byte: work out every codepoint it completes
    function void note_byte(logic [7:0] b, bit last);
      int unsigned first;
      int unsigned need;
      int unsigned i;
      logic [20:0] val;
      bit          ok;
      first = expected_cps.size();
      if (held_cnt >= 4) held_cnt = 0;
      held[held_cnt] = b;
      held_cnt++;
      while (held_cnt > 0) begin
        if (held[0][7] == 1'b0) begin
          push_cp({13'd0, held[0]}, 0, 1);
          drop_held(1);
          continue;
        end
        if (held[0][7:5] == 3'b110) begin
          need = 2;
          val  = {16'd0, held[0][4:0]};
        end else if (held[0][7:4] == 4'b1110) begin
          need = 3;
          val  = {17'd0, held[0][3:0]};
        end else if (held[0][7:3] == 5'b11110) begin
          need = 4;
          val  = {18'd0, held[0][2:0]};
        end else begin
          push_cp(ReplCp, 1, 1);
          drop_held(1);
          continue;
        end
        if (held_cnt < need) begin
          if (!last) break;
          // cut short by the end of text: one replacement eats the rest
          push_cp(ReplCp, 1, held_cnt);
          drop_held(held_cnt);
          continue;
        end
        ok = 1;
        for (i = 1; i < need; i++) begin
          if (held[i][7:6] != 2'b10) ok = 0;
          val = {val[14:0], held[i][5:0]};
        end
        if (!ok) begin
          push_cp(ReplCp, 1, 1);
          drop_held(1);
        end else begin
          push_cp(val, 0, need);
          drop_held(need);
        end
      end
      if (expected_cps.size() > first) begin
        expected_cps[expected_cps.size() - 1].run_last  = 1'b1;
        expected_cps[expected_cps.size() - 1].ends_text = last;
      end
      if (last) begin
        held_cnt     = 0;
        in_cluster   = 0;
        after_joiner = 0;
      end
    endfunction

    function void compare_field(string name, logic [20:0] want, logic [20:0] got);
      if (got !== want) begin
        if (failures < 100) $error("%s: expected %0h, actual %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_codepoint(result_t got);
      result_t want;
      if (expected_cps.size() == 0) begin
        if (failures < 100) $error("code_point: expected none, actual %0h", got.code_point);
        failures++;
        return;
      end
      want = expected_cps.pop_front();
      compare_field("code_point", want.code_point, got.code_point);
      compare_field("is_replacement", want.is_replacement, got.is_replacement);
      compare_field("source_len", want.source_len, got.source_len);
      compare_field("starts_cluster", want.starts_cluster, got.starts_cluster);
      compare_field("cell_width", want.cell_width, got.cell_width);
      compare_field("run_last", want.run_last, got.run_last);
      compare_field("ends_text", want.ends_text, got.ends_text);
    endfunction

    function int unsigned waiting();
      return expected_cps.size();
    endfunction

    function void finish_check();
      if (expected_cps.size() != 0) begin
        $error("%0d codepoints expected but never delivered", expected_cps.size());
        failures++;
      end
    endfunction
  endclass

endpackage

>>> tb/sv/utf8_decode_grapheme_width_top_test.sv
// testbench for the utf-8 decoder: directed and random texts against a predictor
`timescale 1ns / 1ps

module utf8_decode_grapheme_width_top_test;
  import u8dgw_pkg::*;
  import u8dgw_tb_pkg::*;

  // run bounds: the hold-off stretch, the drain wait and the overall cycle budget
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit  = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        text_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [20:0] code_point;
  logic        is_replacement;
  logic [2:0]  source_len;
  logic        starts_cluster;
  logic [1:0]  cell_width;
  logic        run_last;
  logic        ends_text;

  // knobs shared between the driver processes
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_req = 0;
  int unsigned cycle_cnt = 0;

  logic [7:0]     text_q[$];
  codepoint_board board = new;

  utf8_decode_grapheme_width_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .in_byte_i        (in_byte),
    .text_end_i       (text_end),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .code_point_o     (code_point),
    .is_replacement_o (is_replacement),
    .source_len_o     (source_len),
    .starts_cluster_o (starts_cluster),
    .cell_width_o     (cell_width),
    .run_last_o       (run_last),
    .ends_text_o      (ends_text)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // every delivered codepoint goes straight to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      board.check_codepoint({code_point, is_replacement, source_len, starts_cluster,
                             cell_width, run_last, ends_text});
    end
  end

  // receiver side: random stall per cycle, plus one long hold-off on request
  // so that the decoder backs up and pushes back on its input
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 0;
      end
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  // offer one byte, with random idle cycles first; returns at the falling
  // edge after the byte was taken, so valid stays high into the next byte
  task automatic send_byte(input logic [7:0] b, input bit last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_byte  = b;
    text_end = last;
    do @(posedge clk_i); while (in_stall);
    board.note_byte(b, last);
    @(negedge clk_i);
  endtask

  // the text in text_q, end mark on its final byte
  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  // a random codepoint, biased toward the classes the decoder treats specially
  function automatic logic [20:0] pick_cp();
    case ($urandom_range(0, 9))
      0, 1: return 21'($urandom_range(0, 21'h7F));
      2: return 21'($urandom_range(21'h80, 21'h7FF));
      3: return 21'($urandom_range(21'h800, 21'hFFFF));
      4: return 21'($urandom_range(21'h10000, 21'h1FFFFF));
      5: begin
        case ($urandom_range(0, 4))
          0: return 21'($urandom_range(21'h0300, 21'h036F));
          1: return 21'($urandom_range(21'h1AB0, 21'h1AFF));
          2: return 21'($urandom_range(21'h1DC0, 21'h1DFF));
          3: return 21'($urandom_range(21'h20D0, 21'h20FF));
          default: return 21'($urandom_range(21'hFE20, 21'hFE2F));
        endcase
      end
      6: return ZwjCp;
      7: return 21'($urandom_range(21'hFE00, 21'hFE0F));
      default: begin
        case ($urandom_range(0, 7))
          0: return 21'($urandom_range(21'h1100, 21'h115F));
          1: return 21'($urandom_range(21'h2E80, 21'hA4CF));
          2: return 21'($urandom_range(21'hAC00, 21'hD7A3));
          3: return 21'($urandom_range(21'hF900, 21'hFAFF));
          4: return 21'($urandom_range(21'hFE10, 21'hFE19));
          5: return 21'($urandom_range(21'hFE30, 21'hFE6F));
          6: return 21'($urandom_range(21'hFF00, 21'hFF60));
          default: return 21'($urandom_range(21'hFFE0, 21'hFFE6));
        endcase
      end
    endcase
  endfunction

  // encode one codepoint; now and then a continuation gets trashed
  task automatic add_codepoint(input logic [20:0] cp);
    logic [7:0] seq[$];
    if (cp < 21'h80) begin
      seq = {cp[7:0]};
    end else if (cp < 21'h800) begin
      seq = '{{3'b110, cp[10:6]}, {2'b10, cp[5:0]}};
    end else if (cp < 21'h10000) begin
      seq = '{{4'b1110, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
    end else begin
      seq = '{{5'b11110, cp[20:18]}, {2'b10, cp[17:12]}, {2'b10, cp[11:6]},
              {2'b10, cp[5:0]}};
    end
    if (seq.size() > 1 && $urandom_range(0, 11) == 0) begin
      seq[$urandom_range(1, seq.size() - 1)] = 8'($urandom_range(0, 255));
    end
    foreach (seq[i]) text_q = {text_q, seq[i]};
  endtask

  // mostly well-formed text, some raw noise, sometimes cut off mid-sequence
  task automatic build_text();
    logic [7:0]  lead;
    int unsigned lead_need;
    text_q.delete();
    repeat ($urandom_range(1, 10)) begin
      if ($urandom_range(0, 9) == 0) text_q = {text_q, 8'($urandom_range(0, 255))};
      else add_codepoint(pick_cp());
    end
    if ($urandom_range(0, 5) == 0) begin
      lead = 8'($urandom_range(8'hC0, 8'hF7));
      lead_need = (lead >= 8'hF0) ? 4 : (lead >= 8'hE0) ? 3 : 2;
      text_q = {text_q, lead};
      repeat ($urandom_range(0, lead_need - 2)) text_q = {text_q, {2'b10, 6'($urandom)}};
    end
  endtask

  task automatic run_random_phase(input int unsigned idle, input int unsigned stall,
                                  input int unsigned nbytes);
    int unsigned sent;
    sent = 0;
    send_idle_pct = idle;
    stall_pct = stall;
    while (sent < nbytes) begin
      build_text();
      sent += text_q.size();
      send_text();
    end
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: control char, plain ascii, combining mark after a base,
    // joiner followed by a char that must join, wide hangul, four-byte form,
    // illegal lead, broken continuation re-decoded, a well-formed U+FFFD,
    // one byte that flushes four codepoints, and a text cut short at its end
    text_q = '{8'h00, 8'h41, 8'hCC, 8'h81, 8'hE2, 8'h80, 8'h8D, 8'h7F,
               8'hEA, 8'hB0, 8'h80, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'hFF,
               8'hE2, 8'h41, 8'hEF, 8'hBF, 8'hBD, 8'hF4, 8'h80, 8'hC0,
               8'h41, 8'hE2, 8'h82};
    send_text();
    // a text that opens with a combining mark still opens a cluster
    text_q = '{8'hCC, 8'h81};
    send_text();
    // one-byte text
    text_q = '{8'h41};
    send_text();

    // random texts over phases of input idling and output stalls; the first phase
    // also gets the long receiver hold-off while bytes keep coming
    hold_req = 1;
    run_random_phase(0, 0, 65);
    run_random_phase(67, 0, 65);
    run_random_phase(0, 67, 65);
    run_random_phase(8, 8, 65);
    in_valid = 1'b0;
    send_idle_pct = 0;

    while (board.waiting() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    board.finish_check();
    if (board.failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
